[rtl/acm_pkg.sv]
// Shared types and constants for the ADC channel peak / EMA monitor.
// No dependencies; used by every module of the block.
package acm_pkg;

    localparam int NUM_CH     = 5;
    localparam int RAW_W      = 12;
    localparam int VAL_W      = 17;
    localparam int COEF_W     = 17;
    localparam int CNT_W      = 32;
    localparam int ALPHA_W    = 16;
    localparam int ALPHA_FRAC = 16;
    localparam int PROD_SHIFT = 12;
    localparam int CH_W       = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CURRENT_GAIN = 2'd0;
    localparam logic [1:0] REG_TEMP_OFFSET  = 2'd1;
    localparam logic [1:0] REG_TEMP_SLOPE   = 2'd2;
    localparam logic [1:0] REG_FILTER_ALPHA = 2'd3;

    localparam logic [15:0] RST_CURRENT_GAIN = 16'd845;
    localparam logic [15:0] RST_TEMP_OFFSET  = 16'd37760;
    localparam logic [16:0] RST_TEMP_SLOPE   = 17'd63360;
    localparam logic [15:0] RST_FILTER_ALPHA = 16'd3277;

    localparam logic [CH_W-1:0] TEMP_CHANNEL = 3'd4;

    typedef logic signed [VAL_W-1:0] t_value;

    // per-step strobes from the sequencer to lanes and merge
    typedef struct packed {
        logic load_prod;
        logic load_val;
        logic update_peak;
        logic reload;
        logic update_ema;
    } t_lane_ctl;

endpackage

[rtl/acm_lane.sv]
// One channel lane: scaling, saturation, peak hold and moving average.
// Depends on acm_pkg.
module acm_lane #(
    parameter int FILTER_FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acm_pkg::t_lane_ctl            i_ctl,
    input  logic                          i_qualify,
    input  logic [acm_pkg::RAW_W-1:0]     i_raw,
    input  logic [acm_pkg::COEF_W-1:0]    i_coef,
    input  logic [15:0]                   i_offset,
    input  logic                          i_negate,
    input  logic [acm_pkg::ALPHA_W-1:0]   i_alpha,
    output acm_pkg::t_value               o_last_value,
    output acm_pkg::t_value               o_peak_value,
    output acm_pkg::t_value               o_filtered,
    output logic                          o_rose
);

    localparam int SW = acm_pkg::VAL_W + FILTER_FRACTION_BITS;
    localparam int DW = SW + 1;
    localparam int PW = acm_pkg::RAW_W + acm_pkg::COEF_W;
    localparam int MW = DW + acm_pkg::ALPHA_W + 1;
    localparam logic signed [acm_pkg::VAL_W+1:0] WIDE_MAX = 19'sd65535;
    localparam logic signed [acm_pkg::VAL_W+1:0] WIDE_MIN = -19'sd65536;

    logic [PW-1:0]                       r_prod;
    acm_pkg::t_value                     r_last;
    acm_pkg::t_value                     r_peak;
    logic signed [SW-1:0]                r_avg;
    logic signed [DW-1:0]                r_step;

    logic [acm_pkg::VAL_W-1:0]           w_scaled;
    logic signed [acm_pkg::VAL_W+1:0]    w_wide;
    acm_pkg::t_value                     n_last;
    logic signed [SW-1:0]                w_target;
    logic signed [DW-1:0]                w_diff;
    logic signed [MW-1:0]                w_mult;

    assign w_scaled = r_prod[PW-1:acm_pkg::PROD_SHIFT];

    always_comb begin
        if (i_negate) begin
            w_wide = $signed({3'b000, i_offset}) - $signed({2'b00, w_scaled});
        end else begin
            w_wide = $signed({2'b00, w_scaled});
        end
        if (w_wide > WIDE_MAX) begin
            n_last = 17'sd65535;
        end else if (w_wide < WIDE_MIN) begin
            n_last = -17'sd65536;
        end else begin
            n_last = w_wide[acm_pkg::VAL_W-1:0];
        end
    end

    // avg += floor(alpha * ((x << F) - avg) / 2^16)
    assign w_target = $signed({r_last, {FILTER_FRACTION_BITS{1'b0}}});
    assign w_diff   = DW'(w_target) - DW'(r_avg);
    assign w_mult   = $signed({1'b0, i_alpha}) * w_diff;

    assign o_rose = (r_last > r_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_peak <= '0;
            r_avg  <= '0;
        end else begin
            if (i_ctl.load_val) begin
                r_last <= n_last;
            end
            if (i_ctl.reload) begin
                r_peak <= r_last;
            end else if (i_ctl.update_peak && (i_qualify || o_rose)) begin
                r_peak <= r_last;
            end
            if (i_ctl.update_ema) begin
                r_avg <= r_avg + SW'(r_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= i_raw * i_coef;
        end
        if (i_ctl.update_peak) begin
            r_step <= DW'(w_mult >>> acm_pkg::ALPHA_FRAC);
        end
    end

    assign o_last_value = r_last;
    assign o_peak_value = r_peak;
    assign o_filtered   = r_avg[SW-1:FILTER_FRACTION_BITS];

endmodule

[rtl/acm_merge.sv]
// Merge stage: sample counter, qualify event, peak counter from lane rise flags.
// Depends on acm_pkg.
module acm_merge #(
    parameter int QUALIFY_COUNT = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acm_pkg::t_lane_ctl            i_ctl,
    input  logic [acm_pkg::NUM_CH-1:0]    i_rose,
    output logic                          o_qualify_evt,
    output logic [acm_pkg::CNT_W-1:0]     o_sample_number,
    output logic [acm_pkg::CNT_W-1:0]     o_peak_number,
    output logic                          o_qualified
);

    logic [acm_pkg::CNT_W-1:0] r_count;
    logic [acm_pkg::CNT_W-1:0] r_peak_count;
    logic                      r_qualified;
    logic                      r_qual_evt;
    logic [acm_pkg::CNT_W-1:0] n_count;

    assign n_count = r_count + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_peak_count <= '0;
            r_qualified  <= 1'b0;
            r_qual_evt   <= 1'b0;
        end else begin
            if (i_ctl.load_prod) begin
                r_count    <= n_count;
                r_qual_evt <= (n_count == acm_pkg::CNT_W'(QUALIFY_COUNT));
            end
            if (i_ctl.reload) begin
                r_peak_count <= r_count;
            end
            if (i_ctl.update_peak) begin
                if (r_qual_evt) begin
                    r_qualified <= 1'b1;
                end
                if (r_qual_evt || (|i_rose)) begin
                    r_peak_count <= r_count;
                end
            end
        end
    end

    assign o_qualify_evt   = r_qual_evt;
    assign o_sample_number = r_count;
    assign o_peak_number   = r_peak_count;
    assign o_qualified     = r_qualified;

endmodule

[rtl/adc_channel_peak_and_ema_monitor_unit.sv]
// Top level of the ADC channel peak / EMA monitor: APB registers, sequencer,
// five lanes, merge stage and result register. Depends on acm_pkg, acm_lane, acm_merge.
//
//  port group | dir | content
//  -----------+-----+------------------------------------------------------------
//  s_axis     | in  | one sample set (tuser=0) or peak reload (tuser=1)
//  m_axis     | out | five results per sample set, channel 0..4, tlast on 4
//  APB        | in  | current_gain, temp_offset, temp_slope, filter_alpha
//
// Steps: a sample request is taken, then three lane steps follow (scale and
// saturate, peak compare with EMA multiply, EMA add), then the result register
// is loaded one channel at a time, channel 0..4, pausing while m_axis stalls.
// The single set of lane registers read by the result stage means a new sample
// is taken only after the fifth result of the last one. A reload gives no result.
// Reset is synchronous, active low; it restores register defaults and clears
// lanes, counters and flags. A stall on m_axis holds the result register and
// pauses result loading; s_axis_tready stays low from acceptance of a sample
// set until the fifth result is loaded.
module adc_channel_peak_and_ema_monitor_unit #(
    parameter int QUALIFY_COUNT        = 3,
    parameter int FILTER_FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // raw_current_a, _b, _c, _d, raw_temperature (12 b each)
    input  logic         s_axis_tuser,  // op
    // stream out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // instant, peak, filtered (17 b each),
                                        // sample_number, peak_sample_number (32 b), qualified
    output logic [2:0]   m_axis_tuser,  // channel
    output logic         m_axis_tlast,
    // APB
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_VAL  = 3'd1;
    localparam logic [2:0] ST_PEAK = 3'd2;
    localparam logic [2:0] ST_EMA  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int NCH = acm_pkg::NUM_CH;
    localparam int CW  = acm_pkg::CNT_W;

    // config registers
    logic [15:0] r_current_gain;
    logic [15:0] r_temp_offset;
    logic [16:0] r_temp_slope;
    logic [15:0] r_filter_alpha;

    // sequencer
    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [2:0]  r_idx;
    acm_pkg::t_lane_ctl w_ctl;
    logic        w_accept;
    logic        w_load_out;

    // result register
    logic                  r_out_valid;
    logic [2:0]            r_out_ch;
    acm_pkg::t_value       r_out_inst;
    acm_pkg::t_value       r_out_peak;
    acm_pkg::t_value       r_out_filt;
    logic [CW-1:0]         r_out_sample;
    logic [CW-1:0]         r_out_peak_num;
    logic                  r_out_qualified;
    logic                  r_out_last;

    // lane and merge outputs
    acm_pkg::t_value       w_last [NCH];
    acm_pkg::t_value       w_peak [NCH];
    acm_pkg::t_value       w_filt [NCH];
    logic [NCH-1:0]        w_rose;
    logic                  w_qual_evt;
    logic [CW-1:0]         w_sample_number;
    logic [CW-1:0]         w_peak_number;
    logic                  w_qualified;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_gain <= acm_pkg::RST_CURRENT_GAIN;
            r_temp_offset  <= acm_pkg::RST_TEMP_OFFSET;
            r_temp_slope   <= acm_pkg::RST_TEMP_SLOPE;
            r_filter_alpha <= acm_pkg::RST_FILTER_ALPHA;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                acm_pkg::REG_CURRENT_GAIN: r_current_gain <= pwdata[15:0];
                acm_pkg::REG_TEMP_OFFSET:  r_temp_offset  <= pwdata[15:0];
                acm_pkg::REG_TEMP_SLOPE:   r_temp_slope   <= pwdata[16:0];
                acm_pkg::REG_FILTER_ALPHA: r_filter_alpha <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            acm_pkg::REG_CURRENT_GAIN: prdata = {16'd0, r_current_gain};
            acm_pkg::REG_TEMP_OFFSET:  prdata = {16'd0, r_temp_offset};
            acm_pkg::REG_TEMP_SLOPE:   prdata = {15'd0, r_temp_slope};
            acm_pkg::REG_FILTER_ALPHA: prdata = {16'd0, r_filter_alpha};
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- sequencer
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // result register takes the next channel when empty or being drained
    assign w_load_out    = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        w_ctl             = '0;
        w_ctl.load_prod   = w_accept && !s_axis_tuser;
        w_ctl.reload      = w_accept && s_axis_tuser;
        w_ctl.load_val    = (r_state == ST_VAL);
        w_ctl.update_peak = (r_state == ST_PEAK);
        w_ctl.update_ema  = (r_state == ST_EMA);
        n_state           = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_ctl.load_prod) begin
                    n_state = ST_VAL;
                end
            end
            ST_VAL:  n_state = ST_PEAK;
            ST_PEAK: n_state = ST_EMA;
            ST_EMA:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_load_out && (r_idx == acm_pkg::TEMP_CHANNEL)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMA) begin
                r_idx <= '0;
            end else if (w_load_out) begin
                r_idx <= r_idx + 3'd1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_ch        <= r_idx;
            r_out_inst      <= w_last[r_idx];
            r_out_peak      <= w_peak[r_idx];
            r_out_filt      <= w_filt[r_idx];
            r_out_sample    <= w_sample_number;
            r_out_peak_num  <= w_peak_number;
            r_out_qualified <= w_qualified;
            r_out_last      <= (r_idx == acm_pkg::TEMP_CHANNEL);
        end
    end

    // -------------------------------------------------------------- lanes
    // lanes 0..3: current = (raw*gain)>>12; lane 4: offset - ((raw*slope)>>12)
    for (genvar g = 0; g < NCH; g++) begin : g_lane
        logic [acm_pkg::COEF_W-1:0] w_coef;
        logic                       w_negate;

        if (g == NCH - 1) begin : g_temp
            assign w_coef   = r_temp_slope;
            assign w_negate = 1'b1;
        end else begin : g_curr
            assign w_coef   = {1'b0, r_current_gain};
            assign w_negate = 1'b0;
        end

        acm_lane #(
            .FILTER_FRACTION_BITS(FILTER_FRACTION_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_qualify   (w_qual_evt),
            .i_raw       (s_axis_tdata[g*acm_pkg::RAW_W +: acm_pkg::RAW_W]),
            .i_coef      (w_coef),
            .i_offset    (r_temp_offset),
            .i_negate    (w_negate),
            .i_alpha     (r_filter_alpha),
            .o_last_value(w_last[g]),
            .o_peak_value(w_peak[g]),
            .o_filtered  (w_filt[g]),
            .o_rose      (w_rose[g])
        );
    end

    acm_merge #(
        .QUALIFY_COUNT(QUALIFY_COUNT)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_rose         (w_rose),
        .o_qualify_evt  (w_qual_evt),
        .o_sample_number(w_sample_number),
        .o_peak_number  (w_peak_number),
        .o_qualified    (w_qualified)
    );

    // ------------------------------------------------------------ outputs
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ch;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'd0, r_out_qualified, r_out_peak_num, r_out_sample,
                            r_out_filt, r_out_peak, r_out_inst};

endmodule

[rtl/acm_checker.sv]
// Port-level checks for the ADC channel peak / EMA monitor, bound to the top.
// Depends on acm_pkg and the top-level port list.
module acm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [63:0]  s_axis_tdata,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [3:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    // tlast marks exactly the temperature channel
    a_last_on_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == acm_pkg::TEMP_CHANNEL)))
        else $error("tlast does not match temperature channel");

    // channels of one sample leave in order without gaps
    a_channel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1)))
        else $error("result channel out of order");

    // a new request is only taken once the fifth result has been loaded
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
        else $error("input ready while a sample is still being emitted");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind adc_channel_peak_and_ema_monitor_unit acm_checker u_acm_checker (.*);

[bench/adc_channel_peak_and_ema_monitor_unit_tb.sv]
// Self-checking bench for adc_channel_peak_and_ema_monitor_unit: a directed table and
// random sample/reload requests are checked against a cycle-free predictor of the monitor.
// Depends on acm_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module adc_channel_peak_and_ema_monitor_unit_tb;

    localparam int QUAL_COUNT   = 3;
    localparam int EMA_FRAC     = 16;
    localparam int CYCLE_LIMIT  = 400000;  // watchdog limit for the whole run
    localparam int HOLD_CYCLES  = 300;     // long output stall, fills the block
    localparam int HOLD_AT      = 60;      // result count that triggers it
    localparam int SETTLE       = 20;      // longer than sample latency and reload latency
    localparam int PHASE_ITEMS  = 62;
    localparam int NUM_PHASES   = 7;
    localparam int DIR_ROWS     = 15;

    // ---------------------------------------------------------------- DUT ports
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;   // raw_current_a, _b, _c, _d, raw_temperature (12 b each)
    logic         s_axis_tuser;   // op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;   // instant, peak, filtered (17 b each),
                                  // sample_number, peak_sample_number (32 b), qualified
    logic [2:0]   m_axis_tuser;   // channel
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    adc_channel_peak_and_ema_monitor_unit #(
        .QUALIFY_COUNT       (QUAL_COUNT),
        .FILTER_FRACTION_BITS(EMA_FRAC)
    ) u_top (.*);

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- types
    typedef struct packed {
        logic [2:0]  channel;
        logic [16:0] instant;
        logic [16:0] peak;
        logic [16:0] filtered;
        logic [31:0] sample_no;
        logic [31:0] peak_no;
        logic        qualified;
        logic        last;
    } t_report;

    // directed row; pinned rows carry instant values read straight off the spec
    typedef struct packed {
        logic               op;
        logic [11:0]        a;
        logic [11:0]        b;
        logic [11:0]        c;
        logic [11:0]        d;
        logic [11:0]        t;
        logic               pinned;
        logic signed [16:0] cur;
        logic signed [16:0] temp;
    } t_dir_row;

    // Runs at reset settings (gain 845, offset 37760, slope 63360, alpha 3277).
    // Full-scale current: (4095*845)>>12 = 844.  Temperature at raw 4095:
    // 37760 - ((4095*63360)>>12) = -25584; at raw 0 it is the offset itself.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1, 17'sd0,   17'sd37760},
        '{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 17'sd844, -17'sd25584},
        // third sample: qualify event, peaks reload before the compare
        '{1'b0, 12'h800, 12'h400, 12'h200, 12'h100, 12'h7FF, 1'b0, 17'sd0,   17'sd0},
        // reload with junk payload - payload must be ignored
        '{1'b1, 12'h123, 12'h456, 12'h789, 12'hABC, 12'hDEF, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'h001, 12'h002, 12'h003, 12'h004, 12'hFFE, 1'b0, 17'sd0,   17'sd0},
        '{1'b1, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'h000, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'hFFF, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'h010, 12'h010, 12'h010, 12'h010, 12'h800, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 1'b0, 17'sd0,   17'sd0},
        '{1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 17'sd0,   17'sd0},
        '{1'b1, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, 17'sd0,   17'sd0},
        '{1'b0, 12'h000, 12'h000, 12'h000, 12'h000, 12'hFFF, 1'b1, 17'sd0,   -17'sd25584}
    };

    // ---------------------------------------------------------------- predictor state
    logic [15:0]        cfg_gain;
    logic [15:0]        cfg_offset;
    logic [16:0]        cfg_slope;
    logic [15:0]        cfg_alpha;
    logic signed [17:0] last_val [acm_pkg::NUM_CH];
    logic signed [17:0] peak_val [acm_pkg::NUM_CH];
    logic signed [33:0] ema_acc  [acm_pkg::NUM_CH];
    logic [31:0]        sample_cnt;
    logic [31:0]        peak_cnt;
    logic               qual_seen;

    t_report reports_due [$];
    int      mismatches;
    int      reports_seen;
    int      cycle_count;
    bit      no_gaps;      // phase-wide: both sides run back to back

    function automatic logic signed [17:0] clamp_q8(input longint v);
        if (v > 65535)
            return 18'sd65535;
        if (v < -65536)
            return -18'sd65536;
        return v[17:0];
    endfunction

    task automatic reset_model();
        cfg_gain   = acm_pkg::RST_CURRENT_GAIN;
        cfg_offset = acm_pkg::RST_TEMP_OFFSET;
        cfg_slope  = acm_pkg::RST_TEMP_SLOPE;
        cfg_alpha  = acm_pkg::RST_FILTER_ALPHA;
        for (int i = 0; i < acm_pkg::NUM_CH; i++) begin
            last_val[i] = '0;
            peak_val[i] = '0;
            ema_acc[i]  = '0;
        end
        sample_cnt = '0;
        peak_cnt   = '0;
        qual_seen  = 1'b0;
    endtask

    // Advance the monitor state by one accepted request and queue the five
    // channel reports a sample set produces (a reload produces none).
    task automatic predict_channel_reports(input logic op,
                                           input logic [acm_pkg::NUM_CH-1:0][11:0] raw,
                                           input bit pinned,
                                           input logic signed [16:0] pin_cur,
                                           input logic signed [16:0] pin_temp);
        longint  prod;
        longint  diff;
        longint  acc;
        bit      rose;
        t_report rep;
        if (op) begin
            for (int i = 0; i < acm_pkg::NUM_CH; i++)
                peak_val[i] = last_val[i];
            peak_cnt = sample_cnt;
            return;
        end
        for (int i = 0; i < 4; i++) begin
            prod = (longint'(raw[i]) * longint'(cfg_gain)) >>> 12;
            last_val[i] = clamp_q8(prod);
        end
        prod = (longint'(raw[4]) * longint'(cfg_slope)) >>> 12;
        last_val[4] = clamp_q8(longint'(cfg_offset) - prod);

        sample_cnt = sample_cnt + 32'd1;
        if (sample_cnt == QUAL_COUNT) begin
            qual_seen = 1'b1;
            for (int i = 0; i < acm_pkg::NUM_CH; i++)
                peak_val[i] = last_val[i];
            peak_cnt = sample_cnt;
        end

        rose = 1'b0;
        for (int i = 0; i < acm_pkg::NUM_CH; i++) begin
            if (last_val[i] > peak_val[i]) begin
                peak_val[i] = last_val[i];
                rose = 1'b1;
            end
        end
        if (rose)
            peak_cnt = sample_cnt;

        // s += floor(alpha * ((x << F) - s) / 2^16)
        for (int i = 0; i < acm_pkg::NUM_CH; i++) begin
            diff = (longint'(last_val[i]) <<< EMA_FRAC) - longint'(ema_acc[i]);
            acc  = longint'(ema_acc[i]) + ((longint'(cfg_alpha) * diff) >>> 16);
            ema_acc[i] = acc[33:0];
        end

        for (int i = 0; i < acm_pkg::NUM_CH; i++) begin
            rep.channel   = 3'(i);
            rep.instant   = last_val[i][16:0];
            if (pinned)
                rep.instant = (i == acm_pkg::NUM_CH - 1) ? pin_temp : pin_cur;
            rep.peak      = peak_val[i][16:0];
            acc           = clamp_q8(longint'(ema_acc[i]) >>> EMA_FRAC);
            rep.filtered  = acc[16:0];
            rep.sample_no = sample_cnt;
            rep.peak_no   = peak_cnt;
            rep.qualified = qual_seen;
            rep.last      = (i == acm_pkg::NUM_CH - 1);
            reports_due.push_back(rep);
        end
    endtask

    // ---------------------------------------------------------------- checking
    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0d] %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got)
            note_error($sformatf("report %0d %s: expected %h, got %h",
                                 reports_seen, name, want, got));
    endtask

    task automatic check_report();
        t_report want;
        if (reports_due.size() == 0) begin
            note_error($sformatf("result on channel %0d with nothing pending", m_axis_tuser));
        end else begin
            want = reports_due.pop_front();
            check_field("channel",   32'(want.channel),   32'(m_axis_tuser));
            check_field("instant",   32'(want.instant),   32'(m_axis_tdata[16:0]));
            check_field("peak",      32'(want.peak),      32'(m_axis_tdata[33:17]));
            check_field("filtered",  32'(want.filtered),  32'(m_axis_tdata[50:34]));
            check_field("sample_no", want.sample_no,      m_axis_tdata[82:51]);
            check_field("peak_no",   want.peak_no,        m_axis_tdata[114:83]);
            check_field("qualified", 32'(want.qualified), 32'(m_axis_tdata[115]));
            check_field("last",      32'(want.last),      32'(m_axis_tlast));
        end
        reports_seen++;
    endtask

    // ---------------------------------------------------------------- APB
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            acm_pkg::REG_CURRENT_GAIN: cfg_gain   = val[15:0];
            acm_pkg::REG_TEMP_OFFSET:  cfg_offset = val[15:0];
            acm_pkg::REG_TEMP_SLOPE:   cfg_slope  = val[16:0];
            acm_pkg::REG_FILTER_ALPHA: cfg_alpha  = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            note_error($sformatf("register %0d readback: expected %h, got %h",
                                 idx, want, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write all four registers, then read them back (upper pwdata bits must drop)
    task automatic program_registers(input logic [31:0] gain, offset, slope, alpha);
        apb_write(acm_pkg::REG_CURRENT_GAIN, gain);
        apb_write(acm_pkg::REG_TEMP_OFFSET,  offset);
        apb_write(acm_pkg::REG_TEMP_SLOPE,   slope);
        apb_write(acm_pkg::REG_FILTER_ALPHA, alpha);
        apb_read_check(acm_pkg::REG_CURRENT_GAIN, 32'(cfg_gain));
        apb_read_check(acm_pkg::REG_TEMP_OFFSET,  32'(cfg_offset));
        apb_read_check(acm_pkg::REG_TEMP_SLOPE,   32'(cfg_slope));
        apb_read_check(acm_pkg::REG_FILTER_ALPHA, 32'(cfg_alpha));
    endtask

    // ---------------------------------------------------------------- stimulus
    // valid stays up after acceptance until the next call (or drain_input)
    // moves it at the following falling edge
    task automatic send_request(input logic op,
                                input logic [acm_pkg::NUM_CH-1:0][11:0] raw,
                                input bit pinned, input logic signed [16:0] pin_cur,
                                input logic signed [16:0] pin_temp);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_channel_reports(op, raw, pinned, pin_cur, pin_temp);
    endtask

    task automatic drain_input();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // block idle: every report back, plus margin for a trailing reload
    task automatic wait_idle();
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // biased toward the converter extremes and both ends of the range
    function automatic logic [11:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 12'h000;
            1:       return 12'hFFF;
            2:       return 12'($urandom_range(0, 15));
            3:       return 12'($urandom_range(4080, 4095));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // ---------------------------------------------------------------- receiver
    // Draws a stall before each result; once, after HOLD_AT results, it holds
    // off for HOLD_CYCLES so the block backs up into its input.
    initial begin
        int gap;
        bit held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = no_gaps ? 0 : $urandom_range(0, 11);
            if (!held && reports_seen >= HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_report();
        end
    end

    // ---------------------------------------------------------------- watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("adc_channel_peak_and_ema_monitor_unit_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence
    initial begin
        logic [acm_pkg::NUM_CH-1:0][11:0] raw;
        t_dir_row                         row;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        reports_seen  = 0;
        no_gaps       = 1'b0;
        reset_model();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset settings
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            send_request(row.op, {row.t, row.d, row.c, row.b, row.a},
                         row.pinned, row.cur, row.temp);
        end

        // random phases; phase 1 and 2 are the register extremes, the last one
        // returns to reset values, every third phase runs without idling
        for (int p = 1; p <= NUM_PHASES; p++) begin
            drain_input();
            wait_idle();
            case (p)
                // max gain/slope/alpha, zero offset: temperature saturates low
                1: program_registers(32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF,
                                     32'h0000_FFFF);
                // zero gain/slope/alpha: average frozen, flat readings
                2: program_registers(32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFE_0000,
                                     32'h0000_0000);
                NUM_PHASES: program_registers(32'(acm_pkg::RST_CURRENT_GAIN),
                                              32'(acm_pkg::RST_TEMP_OFFSET),
                                              32'(acm_pkg::RST_TEMP_SLOPE),
                                              32'(acm_pkg::RST_FILTER_ALPHA));
                default: program_registers($urandom, $urandom, $urandom, $urandom);
            endcase
            no_gaps = (p % 3 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                for (int c = 0; c < acm_pkg::NUM_CH; c++)
                    raw[c] = pick_raw();
                send_request($urandom_range(0, 99) < 12, raw, 1'b0, 17'sd0, 17'sd0);
            end
        end

        drain_input();
        no_gaps = 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("adc_channel_peak_and_ema_monitor_unit_tb passed");
        else
            $display("adc_channel_peak_and_ema_monitor_unit_tb failed");
        $finish;
    end

endmodule

[adc_channel_peak_and_ema_monitor_unit.f]
rtl/acm_pkg.sv
rtl/acm_lane.sv
rtl/acm_merge.sv
rtl/adc_channel_peak_and_ema_monitor_unit.sv
rtl/acm_checker.sv
bench/adc_channel_peak_and_ema_monitor_unit_tb.sv
